// File: src/qir_pkg.sv
`default_nettype none

package qir_pkg;

    localparam int QIR_VALUE_WIDTH    = 48;
    localparam int QIR_ROOT_TOLERANCE = 1;
    localparam logic [63:0] QIR_STEP_RESET = 64'd4294967;

    localparam logic OP_ROOT = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NEG_DISC  = 2'd1,
        STAT_ZERO_LEAD = 2'd2,
        STAT_SAT       = 2'd3
    } status_t;

endpackage

`default_nettype wire

// File: src/qir_delay.sv
`default_nettype none

module qir_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// File: src/qir_mul.sv
`default_nettype none

module qir_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int XW = NA * 32;
    localparam int YW = NB * 32;
    localparam int FW = XW + YW;
    localparam int PW = AW + BW;

    logic [AW-1:0] mag_a;
    logic [BW-1:0] mag_b;
    logic [XW-1:0] ua_reg;
    logic [YW-1:0] ub_reg;
    logic          neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]   pp_reg [NA][NB];
    logic [FW-1:0] sum_next, sum_reg;
    logic signed [PW-1:0] p_reg;

    assign mag_a = a[AW-1] ? AW'(-a) : AW'(a);
    assign mag_b = b[BW-1] ? BW'(-b) : BW'(b);

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum_next = sum_next + (FW'(pp_reg[i][j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= XW'(mag_a);
            ub_reg   <= YW'(mag_b);
            neg1_reg <= a[AW-1] ^ b[BW-1];
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= 64'(ua_reg[32*i +: 32]) * 64'(ub_reg[32*j +: 32]);
                end
            end
            neg2_reg <= neg1_reg;
            sum_reg  <= sum_next;
            neg3_reg <= neg2_reg;
            p_reg    <= neg3_reg ? -$signed(sum_reg[PW-1:0]) : $signed(sum_reg[PW-1:0]);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: src/qir_sqrt.sv
`default_nettype none

module qir_sqrt #(
    parameter int RW = 64
) (
    input  logic              clk,
    input  logic              en,
    input  logic [RW-1:0]     rad,
    output logic [RW/2-1:0]   root
);

    localparam int SW = RW / 2;
    localparam int MW = SW + 3;

    logic [RW-1:0] rad_s  [0:SW];
    logic [MW-1:0] rem_s  [0:SW];
    logic [SW-1:0] root_s [0:SW];

    assign rad_s[0]  = rad;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;

    for (genvar i = 0; i < SW; i++)
    begin : g_stage
        logic [MW-1:0] rem_sh, trial;
        logic [RW-1:0] rad_reg;
        logic [MW-1:0] rem_reg;
        logic [SW-1:0] root_reg;

        assign rem_sh = {rem_s[i][MW-3:0], rad_s[i][RW-1:RW-2]};
        assign trial  = MW'({root_s[i], 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg <= rad_s[i] << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_s[i][SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_s[i][SW-2:0], 1'b0};
                end
            end
        end

        assign rad_s[i+1]  = rad_reg;
        assign rem_s[i+1]  = rem_reg;
        assign root_s[i+1] = root_reg;
    end

    assign root = root_s[SW];

endmodule

`default_nettype wire

// File: src/qir_div.sv
`default_nettype none

module qir_div #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic signed [NW:0]   q
);

    localparam int QW = NW + 1;

    logic [NW-1:0] uq_s  [0:NW];
    logic [DW-1:0] rem_s [0:NW];
    logic [DW-1:0] ud_s  [0:NW];
    logic          neg_s [0:NW];

    logic [NW-1:0] un0_reg;
    logic [DW-1:0] ud0_reg;
    logic          neg0_reg;
    logic [QW-1:0] qf;
    logic signed [QW-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un0_reg  <= num[NW-1] ? NW'(-num) : NW'(num);
            ud0_reg  <= den[DW-1] ? DW'(-den) : DW'(den);
            neg0_reg <= num[NW-1] ^ den[DW-1];
        end
    end

    assign uq_s[0]  = un0_reg;
    assign rem_s[0] = '0;
    assign ud_s[0]  = ud0_reg;
    assign neg_s[0] = neg0_reg;

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic [DW:0]   rem_sh;
        logic          ge;
        logic [NW-1:0] uq_reg;
        logic [DW-1:0] rem_reg;
        logic [DW-1:0] ud_reg;
        logic          neg_reg;

        assign rem_sh = {rem_s[i], uq_s[i][NW-1]};
        assign ge     = rem_sh >= (DW+1)'(ud_s[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                uq_reg  <= {uq_s[i][NW-2:0], ge};
                rem_reg <= ge ? DW'(rem_sh - (DW+1)'(ud_s[i])) : DW'(rem_sh);
                ud_reg  <= ud_s[i];
                neg_reg <= neg_s[i];
            end
        end

        assign uq_s[i+1]  = uq_reg;
        assign rem_s[i+1] = rem_reg;
        assign ud_s[i+1]  = ud_reg;
        assign neg_s[i+1] = neg_reg;
    end

    assign qf = QW'(uq_s[NW]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!neg_s[NW])
            begin
                q_reg <= qf;
            end
            else if (rem_s[NW] != '0)
            begin
                q_reg <= ~qf;
            end
            else
            begin
                q_reg <= -qf;
            end
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: src/quadratic_interpolation_root_eval_top.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata samples and times, tuser op
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata value, tuser status
// cfg       in   cfg_valid/cfg_ready            cfg_data step size
//
// One item per cycle while the output is not stalled; the pipeline holds
// the bit-serial square root (VALUE_WIDTH+3 stages) and the
// one-bit-per-stage floor divider (3*VALUE_WIDTH+7 stages).
// Reset clears valid bits and loads the default step size.
// A stalled output freezes every stage but the step-size square multiplier; nothing is lost or repeated.
`default_nettype none

module quadratic_interpolation_root_eval_top
    import qir_pkg::*;
#(
    parameter int VALUE_WIDTH    = QIR_VALUE_WIDTH,
    parameter int ROOT_TOLERANCE = QIR_ROOT_TOLERANCE
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // last_time, sample_old, sample_mid, sample_new, eval_time
    input  logic [((5*VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // op
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // value
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // status
    output logic [1:0]                            m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [VALUE_WIDTH-2:0]                cfg_data
);

    localparam int W     = VALUE_WIDTH;
    localparam int AW    = W + 2;
    localparam int TW    = W + 3;
    localparam int HW    = W + 1;
    localparam int DSW   = 2 * W + 6;
    localparam int SW    = DSW / 2;
    localparam int SSW   = W + 5;
    localparam int NUMW  = 3 * W + 5;
    localparam int DENW  = 2 * W + 1;
    localparam int QW    = NUMW + 1;
    localparam int SUMW  = QW + 1;
    localparam int LM    = 4;
    localparam int LD    = NUMW + 2;
    localparam int K_F   = 11 + SW + LD;
    localparam int K_OUT = K_F + 2;
    localparam int ODW   = ((W + 7) / 8) * 8;
    localparam int SDW   = W + 2;

    logic                 adv;
    logic [K_OUT:0]       valid_reg;
    logic [W-2:0]         step_reg;
    logic [W-2:0]         dt_eff;
    logic signed [W-1:0]  dt_s;

    // stage 0
    logic                 op0_reg;
    logic signed [W-1:0]  x2_reg, y0_reg, y1_reg, y2_reg, t_reg;
    // stage 1
    logic signed [AW-1:0] a1_reg;
    logic signed [TW-1:0] t1_reg;
    logic signed [HW-1:0] h1_reg;
    logic signed [W-1:0]  y21_reg;
    logic [SDW-1:0]       side1_reg;

    assign adv           = !valid_reg[K_OUT] || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;
    assign dt_eff        = (step_reg == '0) ? (W-1)'(1) : step_reg;
    assign dt_s          = $signed({1'b0, dt_eff});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            step_reg  <= (W-1)'(QIR_STEP_RESET);
        end
        else
        begin
            if (adv)
            begin
                valid_reg <= {valid_reg[K_OUT-1:0], s_axis_tvalid};
            end
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg <= s_axis_tuser;
            x2_reg  <= s_axis_tdata[0*W +: W];
            y0_reg  <= s_axis_tdata[1*W +: W];
            y1_reg  <= s_axis_tdata[2*W +: W];
            y2_reg  <= s_axis_tdata[3*W +: W];
            t_reg   <= s_axis_tdata[4*W +: W];
        end
    end

    logic signed [AW-1:0] a_next;
    logic signed [TW-1:0] t_next;

    assign a_next = AW'(y0_reg) - (AW'(y1_reg) <<< 1) + AW'(y2_reg);
    assign t_next = TW'(y0_reg) - (TW'(y1_reg) <<< 2) + (TW'(y2_reg) <<< 1) + TW'(y2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg    <= a_next;
            t1_reg    <= t_next;
            h1_reg    <= HW'(t_reg) - HW'(x2_reg);
            y21_reg   <= y2_reg;
            side1_reg <= {op0_reg, (a_next == '0), (op0_reg == OP_EVAL) ? y2_reg : x2_reg};
        end
    end

    // first multiplier bank
    logic signed [2*TW-1:0]   tt;
    logic signed [AW+W-1:0]   ay;
    logic signed [TW+HW-1:0]  th;
    logic signed [2*HW-1:0]   hh;
    logic signed [2*W-1:0]    dd;

    qir_mul #(.AW(TW), .BW(TW)) u_mul_tt (.clk(clk), .en(adv), .a(t1_reg), .b(t1_reg), .p(tt));
    qir_mul #(.AW(AW), .BW(W))  u_mul_ay (.clk(clk), .en(adv), .a(a1_reg), .b(y21_reg),
                                          .p(ay));
    qir_mul #(.AW(TW), .BW(HW)) u_mul_th (.clk(clk), .en(adv), .a(t1_reg), .b(h1_reg), .p(th));
    qir_mul #(.AW(HW), .BW(HW)) u_mul_hh (.clk(clk), .en(adv), .a(h1_reg), .b(h1_reg), .p(hh));
    qir_mul #(.AW(W), .BW(W))   u_mul_dd (.clk(clk), .en(1'b1), .a(dt_s), .b(dt_s), .p(dd));

    logic [AW-1:0]  a5;
    logic [SDW-1:0] side5;

    qir_delay #(.WIDTH(AW), .DEPTH(LM))  u_dly_a5 (.clk(clk), .en(adv), .din(a1_reg), .dout(a5));
    qir_delay #(.WIDTH(SDW), .DEPTH(LM)) u_dly_s5 (.clk(clk), .en(adv), .din(side1_reg),
                                                  .dout(side5));

    // discriminant
    logic signed [DSW-1:0] disc_next, disc_reg;
    logic [SDW:0]          side6_reg;

    assign disc_next = DSW'(tt) - (DSW'(ay) <<< 3);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            disc_reg  <= disc_next;
            side6_reg <= {side5, disc_next[DSW-1]};
        end
    end

    // op 1 numerator
    logic signed [3*W+3:0]  thd;
    logic signed [3*W+3:0]  ahh;
    logic signed [NUMW-1:0] num1_reg;
    logic [NUMW-1:0]        num1_d;

    qir_mul #(.AW(TW+HW), .BW(W))  u_mul_thd (.clk(clk), .en(adv), .a(th), .b(dt_s), .p(thd));
    qir_mul #(.AW(AW), .BW(2*HW))  u_mul_ahh (.clk(clk), .en(adv), .a($signed(a5)), .b(hh),
                                              .p(ahh));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_reg <= NUMW'(thd) + NUMW'(ahh);
        end
    end

    qir_delay #(.WIDTH(NUMW), .DEPTH(SW+1)) u_dly_num1 (.clk(clk), .en(adv), .din(num1_reg),
                                                       .dout(num1_d));

    // op 0 roots
    logic [SW-1:0]         root;
    logic [TW-1:0]         t_d;
    logic signed [SSW-1:0] tx, sx, nps_reg, nms_reg;

    qir_sqrt #(.RW(DSW)) u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (disc_reg[DSW-1] ? '0 : disc_reg),
        .root (root)
    );

    qir_delay #(.WIDTH(TW), .DEPTH(5+SW)) u_dly_t (.clk(clk), .en(adv), .din(t1_reg),
                                                  .dout(t_d));

    assign tx = -SSW'($signed(t_d));
    assign sx = $signed(SSW'(root));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nps_reg <= tx + sx;
            nms_reg <= tx - sx;
        end
    end

    logic signed [SSW+W-1:0] p1, p2;

    qir_mul #(.AW(SSW), .BW(W)) u_mul_p1 (.clk(clk), .en(adv), .a(nps_reg), .b(dt_s), .p(p1));
    qir_mul #(.AW(SSW), .BW(W)) u_mul_p2 (.clk(clk), .en(adv), .a(nms_reg), .b(dt_s), .p(p2));

    logic [AW-1:0] a_d;
    logic          op_d;

    qir_delay #(.WIDTH(AW), .DEPTH(6+SW)) u_dly_ad (.clk(clk), .en(adv), .din(a5), .dout(a_d));
    qir_delay #(.WIDTH(1), .DEPTH(5+SW))  u_dly_op (.clk(clk), .en(adv),
                                                  .din(side6_reg[SDW]), .dout(op_d));

    // dividers
    logic signed [DENW-1:0] den0, den1;
    logic signed [NUMW-1:0] numa;
    logic signed [DENW-1:0] dena;
    logic signed [QW-1:0]   qa, qb;

    assign den0 = DENW'($signed(a_d)) <<< 1;
    assign den1 = DENW'(dd) <<< 1;
    assign numa = (op_d == OP_EVAL) ? $signed(num1_d) : NUMW'(p1);
    assign dena = (op_d == OP_EVAL) ? den1 : den0;

    qir_div #(.NW(NUMW), .DW(DENW)) u_div_a (.clk(clk), .en(adv), .num(numa), .den(dena), .q(qa));
    qir_div #(.NW(NUMW), .DW(DENW)) u_div_b (.clk(clk), .en(adv), .num(NUMW'(p2)), .den(den0),
                                             .q(qb));

    logic [SDW:0] side_f;

    qir_delay #(.WIDTH(SDW+1), .DEPTH(K_F-6)) u_dly_side (.clk(clk), .en(adv), .din(side6_reg),
                                                         .dout(side_f));

    // select, add base, saturate
    logic                  op_f, azero_f, dneg_f;
    logic signed [W-1:0]   base_f;
    logic signed [QW-1:0]  tol_lim, lo_lim, hsel;
    logic                  in_win;
    logic signed [SUMW-1:0] sum_reg, max_lim, min_lim;
    status_t               pre_reg, status_reg;
    logic [W-1:0]          value_reg;

    assign op_f    = side_f[SDW];
    assign azero_f = side_f[SDW-1];
    assign base_f  = $signed(side_f[W:1]);
    assign dneg_f  = side_f[0];
    assign tol_lim = QW'(ROOT_TOLERANCE);
    assign lo_lim  = -(QW'({dt_eff, 1'b0})) - tol_lim;
    assign in_win  = (qa > lo_lim) && (qa < tol_lim);
    assign hsel    = ((op_f == OP_EVAL) || in_win) ? qa : qb;
    assign max_lim = SUMW'({1'b0, {(W-1){1'b1}}});
    assign min_lim = -max_lim - SUMW'(1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= SUMW'(base_f) + SUMW'(hsel);
            if (op_f == OP_ROOT && azero_f)
            begin
                pre_reg <= STAT_ZERO_LEAD;
            end
            else if (op_f == OP_ROOT && dneg_f)
            begin
                pre_reg <= STAT_NEG_DISC;
            end
            else
            begin
                pre_reg <= STAT_OK;
            end

            if (pre_reg != STAT_OK)
            begin
                value_reg  <= '0;
                status_reg <= pre_reg;
            end
            else if (sum_reg > max_lim)
            begin
                value_reg  <= {1'b0, {(W-1){1'b1}}};
                status_reg <= STAT_SAT;
            end
            else if (sum_reg < min_lim)
            begin
                value_reg  <= {1'b1, {(W-1){1'b0}}};
                status_reg <= STAT_SAT;
            end
            else
            begin
                value_reg  <= sum_reg[W-1:0];
                status_reg <= STAT_OK;
            end
        end
    end

    assign m_axis_tvalid = valid_reg[K_OUT];
    assign m_axis_tdata  = ODW'(value_reg);
    assign m_axis_tuser  = status_reg;

    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status_reg == STAT_NEG_DISC || status_reg == STAT_ZERO_LEAD)
        |-> value_reg == '0)
        else $error("error status with nonzero value");

    a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status_reg == STAT_SAT
        |-> (value_reg == {1'b0, {(W-1){1'b1}}} || value_reg == {1'b1, {(W-1){1'b0}}}))
        else $error("saturated value not at a limit");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> m_axis_tvalid && $stable(value_reg) && $stable(status_reg))
        else $error("stalled pipeline changed its output");

endmodule

`default_nettype wire

// File: tb/sv/quadratic_interpolation_root_eval_top_test.sv
`default_nettype none

module quadratic_interpolation_root_eval_top_test;
    import qir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = QIR_VALUE_WIDTH;
    localparam int LATENCY = 4*VW + 23;
    localparam longint CYCLE_LIMIT = 600000;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic                 op;
        logic signed [VW-1:0] eval_time;
        logic signed [VW-1:0] sample_new;
        logic signed [VW-1:0] sample_mid;
        logic signed [VW-1:0] sample_old;
        logic signed [VW-1:0] last_time;
    } quad_item_t;

    typedef struct packed {
        logic [VW-1:0] value;
        status_t       status;
    } quad_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [239:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [VW-2:0] cfg_data = '0;

    quad_item_t   pending_items[$];
    quad_result_t expected_results[$];
    logic [VW-2:0] step_cur = QIR_STEP_RESET[VW-2:0];
    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    bit  hold_request = 1'b0;
    bit  hold_seen = 1'b0;
    bit  in_fire = 1'b0;
    int  hold_left = 0;
    int  error_count = 0;
    longint cycle_count = 0;

    quadratic_interpolation_root_eval_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // last_time, sample_old, sample_mid, sample_new, eval_time
        .s_axis_tuser  (s_axis_tuser),   // op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // value
        .m_axis_tuser  (m_axis_tuser),   // status
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic wide_t floor_div(input wide_t n, input wide_t d);
        wide_t q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic quad_result_t predict_quadratic(input quad_item_t it,
                                                       input logic [VW-2:0] step);
        wide_t dt, x2, y0, y1, y2, a, tc, disc, root, c, den, h, lo, tol, res;
        wide_t vmax, vmin;
        quad_result_t r;
        dt = (step == 0) ? wide_t'(1) : wide_t'(step);
        x2 = wide_t'(it.last_time);
        y0 = wide_t'(it.sample_old);
        y1 = wide_t'(it.sample_mid);
        y2 = wide_t'(it.sample_new);
        a  = y0 - 2*y1 + y2;
        tc = y0 - 4*y1 + 3*y2;
        tol = wide_t'(QIR_ROOT_TOLERANCE);
        vmax = (wide_t'(1) <<< (VW-1)) - 1;
        vmin = -(wide_t'(1) <<< (VW-1));
        if (it.op == OP_ROOT)
        begin
            if (a == 0)
            begin
                r.value = '0;
                r.status = STAT_ZERO_LEAD;
                return r;
            end
            disc = tc*tc - 8*a*y2;
            if (disc < 0)
            begin
                r.value = '0;
                r.status = STAT_NEG_DISC;
                return r;
            end
            root = 0;
            for (int i = 110; i >= 0; i--)
            begin
                c = root | (wide_t'(1) <<< i);
                if (c*c <= disc)
                    root = c;
            end
            den = 2*a;
            h = floor_div(dt*(root - tc), den);
            lo = -(2*dt) - tol;
            if (!(lo < h && h < tol))
                h = floor_div(dt*(-tc - root), den);
            res = x2 + h;
        end
        else
        begin
            h = wide_t'(it.eval_time) - x2;
            res = y2 + floor_div(tc*h*dt + a*h*h, 2*dt*dt);
        end
        if (res > vmax)
        begin
            r.value = vmax[VW-1:0];
            r.status = STAT_SAT;
        end
        else if (res < vmin)
        begin
            r.value = vmin[VW-1:0];
            r.status = STAT_SAT;
        end
        else
        begin
            r.value = res[VW-1:0];
            r.status = STAT_OK;
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] rand_full();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] rand_near(input int bits);
        logic signed [63:0] v;
        v = $signed({$urandom, $urandom}) >>> (64 - bits);
        return v[VW-1:0];
    endfunction

    function automatic quad_item_t rand_item();
        quad_item_t it;
        int kind;
        logic signed [VW-1:0] r0, r1, k;
        kind = $urandom_range(99);
        it.op = 1'($urandom_range(1));
        it.last_time = rand_near($urandom_range(20, 44));
        it.eval_time = it.last_time + rand_near($urandom_range(8, 40));
        if (kind < 15)
        begin
            it.last_time = rand_full();
            it.sample_old = rand_full();
            it.sample_mid = rand_full();
            it.sample_new = rand_full();
            it.eval_time = rand_full();
        end
        else if (kind < 25)
        begin
            // straight line: zero leading coefficient
            it.sample_old = rand_near(44);
            k = rand_near(40);
            it.sample_mid = it.sample_old + k;
            it.sample_new = it.sample_old + 2*k;
        end
        else if (kind < 70)
        begin
            // parabola with roots near the sample window
            r0 = -$signed(VW'($urandom_range(0, 3*4096)));
            r1 = r0 + $signed(VW'($urandom_range(1, 8192)));
            k  = rand_near(12);
            if (k == 0)
                k = 1;
            it.sample_new = k*(0 - r0)*(0 - r1);
            it.sample_mid = k*(-4096 - r0)*(-4096 - r1);
            it.sample_old = k*(-8192 - r0)*(-8192 - r1);
        end
        else
        begin
            it.sample_old = rand_near($urandom_range(8, 48));
            it.sample_mid = rand_near($urandom_range(8, 48));
            it.sample_new = rand_near($urandom_range(8, 48));
        end
        return it;
    endfunction

    function automatic quad_item_t make_item(input logic op, input logic [VW-1:0] x2,
                                             input logic [VW-1:0] y0, input logic [VW-1:0] y1,
                                             input logic [VW-1:0] y2, input logic [VW-1:0] t);
        quad_item_t it;
        it.op = op;
        it.last_time = x2;
        it.sample_old = y0;
        it.sample_mid = y1;
        it.sample_new = y2;
        it.eval_time = t;
        return it;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                quad_item_t it;
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {it.eval_time, it.sample_new, it.sample_mid,
                                 it.sample_old, it.last_time};
                s_axis_tuser <= it.op;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        int left;
        left = hold_left;
        if (hold_request && !hold_seen)
        begin
            hold_seen <= 1'b1;
            left = 800;
        end
        else if (left > 0)
        begin
            left = left - 1;
        end
        hold_left <= left;
        m_axis_tready <= rst_n && left == 0 && $urandom_range(99) >= snk_stall_pct;
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("quadratic_interpolation_root_eval_top_test: errors");
            $finish;
        end
        else
        begin
            if (rst_n && s_axis_tvalid && s_axis_tready)
            begin
                quad_item_t it;
                it.last_time  = s_axis_tdata[47:0];
                it.sample_old = s_axis_tdata[95:48];
                it.sample_mid = s_axis_tdata[143:96];
                it.sample_new = s_axis_tdata[191:144];
                it.eval_time  = s_axis_tdata[239:192];
                it.op         = s_axis_tuser;
                expected_results.push_back(predict_quadratic(it, step_cur));
            end
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result value=%h status=%0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    quad_result_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (m_axis_tdata !== exp_r.value)
                    begin
                        $display("%0t value mismatch: expected %h actual %h",
                                 $time, exp_r.value, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== exp_r.status)
                    begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, exp_r.status, m_axis_tuser);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic write_step(input logic [VW-2:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        step_cur = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic run_phase(input logic [VW-2:0] step, input int src_pct,
                             input int snk_pct, input int count);
        write_step(step);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < count; i++)
            pending_items.push_back(rand_item());
        drain();
    endtask

    initial
    begin
        logic [VW-1:0] vmax, vmin, one;
        vmax = {1'b0, {(VW-1){1'b1}}};
        vmin = {1'b1, {(VW-1){1'b0}}};
        one = VW'(64'h1_0000_0000);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default step, directed items
        pending_items.push_back(make_item(OP_ROOT, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_ROOT, vmax, vmax, vmax, vmax, vmax));
        pending_items.push_back(make_item(OP_ROOT, vmin, vmin, vmin, vmin, vmin));
        pending_items.push_back(make_item(OP_EVAL, vmax, vmax, vmin, vmax, vmin));
        pending_items.push_back(make_item(OP_EVAL, vmin, vmin, vmax, vmin, vmax));
        pending_items.push_back(make_item(OP_EVAL, vmin, vmax, vmax, vmax, vmax));
        pending_items.push_back(make_item(OP_ROOT, one, one, 0, one, vmax));
        pending_items.push_back(make_item(OP_ROOT, 0, -one, 0, -one, 0));
        pending_items.push_back(make_item(OP_ROOT, one, one, 2*one, 3*one, 0));
        pending_items.push_back(make_item(OP_ROOT, 0, 4*one, one, 0, 0));
        pending_items.push_back(make_item(OP_ROOT, 0, 0, one, 4*one, 0));
        pending_items.push_back(make_item(OP_ROOT, vmax, 0, -one, 0, 0));
        pending_items.push_back(make_item(OP_ROOT, vmin, 0, one, 0, 0));
        pending_items.push_back(make_item(OP_EVAL, one, one, 2*one, 3*one, vmax));
        pending_items.push_back(make_item(OP_EVAL, 0, -1, 1, -1, -1));
        pending_items.push_back(make_item(OP_ROOT, 0, 1, 0, 1, 0));
        pending_items.push_back(make_item(OP_ROOT, 0, 1, 0, -1, 0));
        drain();

        // no idling in the first phase, with a long receiver hold-off to fill the pipeline
        write_step(QIR_STEP_RESET[VW-2:0]);
        hold_request = 1'b1;
        run_phase(QIR_STEP_RESET[VW-2:0], 0, 0, 350);
        run_phase((VW-1)'(1), 74, 0, 250);
        run_phase({(VW-1){1'b1}}, 0, 74, 250);
        run_phase('0, 38, 38, 150);
        run_phase((VW-1)'(4096), 38, 38, 200);
        run_phase((VW-1)'($urandom_range(1, 32'h7fff_ffff)), 0, 0, 100);

        if (error_count == 0)
            $display("quadratic_interpolation_root_eval_top_test: clean");
        else
            $display("quadratic_interpolation_root_eval_top_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
